// ----- rtl/core/isp_pkg.sv -----
`default_nettype none

package isp_pkg;

  localparam int unsigned MaxIntervalsDefault = 64;
  localparam int unsigned CoordWidthDefault   = 32;

  // Fixed widths of the command fields.
  localparam int unsigned PointWidth = 32;
  localparam int unsigned SelWidth   = 6;

  typedef enum logic [2:0] {
    StCovered  = 3'd0,
    StNew      = 3'd1,
    StGrewDown = 3'd2,
    StGrewUp   = 3'd3,
    StJoined   = 3'd4,
    StFull     = 3'd5,
    StReadOk   = 3'd6,
    StReadBad  = 3'd7
  } isp_status_e;

  typedef enum logic [0:0] {
    CmdInsert = 1'b0,
    CmdRead   = 1'b1
  } isp_cmd_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SDecide,
    SMove
  } isp_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/interval_set_point_coalescer.sv -----
`default_nettype none

// Interval set with point coalescing. A transaction is taken when start is high
// and busy is low; exactly one status comes back on status_o, marked by a
// one-cycle done_o pulse that the receiver must take as it comes. A read
// transaction is answered from the idle state and changes nothing. An insert
// transaction scans the n stored intervals (up to MAX_INTERVALS) and, when two
// intervals join, moves the last entry into the freed slot; it can
// end early when a stored interval already covers the point. The scan reads
// the two interval memories (one read and one write port each), one entry per
// cycle, followed by the write-back of up to two entries. Coordinates are stored with
// the sign bit flipped so that unsigned compares order them as signed values.
// Entries at or above the count are never examined, so the memories need no
// clearing after reset.
module interval_set_point_coalescer
  import isp_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervalsDefault,
  parameter int unsigned COORD_WIDTH   = CoordWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic                  cmd_i,
  input  wire logic [PointWidth-1:0] point_i,
  input  wire logic [SelWidth-1:0]   entry_select_i,
  output      logic                  done_o,
  output      logic [2:0]            status_o
);

  localparam int unsigned IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned CmpW = (CntW > SelWidth) ? CntW : SelWidth;
  localparam int unsigned ExtW = 64;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // Interval storage, biased coordinates.
  coord_t low_mem  [MAX_INTERVALS];
  coord_t high_mem [MAX_INTERVALS];

  isp_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;
  coord_t          b_q, b_d;
  logic            have_lo_q, have_lo_d;
  logic            have_hi_q, have_hi_d;
  logic [IdxW-1:0] lo_idx_q, lo_idx_d;
  logic [IdxW-1:0] hi_idx_q, hi_idx_d;
  coord_t          hi_high_q, hi_high_d;
  coord_t          last_low_q, last_low_d;
  coord_t          last_high_q, last_high_d;
  logic            done_q, done_d;
  logic [2:0]      status_q, status_d;

  coord_t          rd_low_q, rd_high_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  logic            low_we, high_we;
  logic [IdxW-1:0] low_waddr, high_waddr;
  coord_t          low_wdata, high_wdata;

  logic [ExtW-1:0] point_ext;
  coord_t          point_b;
  coord_t          b_inc, b_dec;
  logic            hit_cover, hit_hi, hit_lo, hit_last;
  logic            accept;

  // Sign-extend, wrap to the coordinate width, then flip the sign bit.
  assign point_ext = {{(ExtW - PointWidth){point_i[PointWidth-1]}}, point_i};
  assign point_b   = point_ext[COORD_WIDTH-1:0] ^ {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  assign b_inc = b_q + coord_t'(1);
  assign b_dec = b_q - coord_t'(1);

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);

  // Scan one returned entry against the latched point. No wrap at the ends.
  assign hit_cover = (rd_low_q <= b_q) && (b_q <= rd_high_q);
  assign hit_hi    = (b_q != '1) && (rd_low_q == b_inc);
  assign hit_lo    = (b_q != '0) && (rd_high_q == b_dec);
  assign hit_last  = ({{(CntW - IdxW){1'b0}}, cmp_idx_q} == (count_q - CntW'(1)));

  assign rd_en   = (state_q == SScan) && (iss_q < count_q);
  assign rd_addr = iss_q[IdxW-1:0];

  // Memories: one read and one write port each, read data registered.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_low_q  <= low_mem[rd_addr];
      rd_high_q <= high_mem[rd_addr];
    end
    if (low_we) begin
      low_mem[low_waddr] <= low_wdata;
    end
    if (high_we) begin
      high_mem[high_waddr] <= high_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    iss_q       <= iss_d;
    cmp_idx_q   <= rd_addr;
    b_q         <= b_d;
    have_lo_q   <= have_lo_d;
    have_hi_q   <= have_hi_d;
    lo_idx_q    <= lo_idx_d;
    hi_idx_q    <= hi_idx_d;
    hi_high_q   <= hi_high_d;
    last_low_q  <= last_low_d;
    last_high_q <= last_high_d;
    status_q    <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iss_d       = iss_q;
    cmp_vld_d   = 1'b0;
    b_d         = b_q;
    have_lo_d   = have_lo_q;
    have_hi_d   = have_hi_q;
    lo_idx_d    = lo_idx_q;
    hi_idx_d    = hi_idx_q;
    hi_high_d   = hi_high_q;
    last_low_d  = last_low_q;
    last_high_d = last_high_q;
    done_d      = 1'b0;
    status_d    = status_q;
    low_we      = 1'b0;
    high_we     = 1'b0;
    low_waddr   = hi_idx_q;
    high_waddr  = lo_idx_q;
    low_wdata   = b_q;
    high_wdata  = b_q;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (cmd_i == CmdRead) begin
            // Answer a read at once; it changes nothing.
            done_d = 1'b1;
            if (CmpW'(entry_select_i) < CmpW'(count_q)) begin
              status_d = StReadOk;
            end else begin
              status_d = StReadBad;
            end
          end else begin
            b_d       = point_b;
            iss_d     = '0;
            have_lo_d = 1'b0;
            have_hi_d = 1'b0;
            state_d   = SScan;
          end
        end
      end

      SScan: begin
        // Issue one read per cycle, check the entry read the cycle before.
        cmp_vld_d = rd_en;
        if (rd_en) begin
          iss_d = iss_q + CntW'(1);
        end
        if (cmp_vld_q && hit_cover) begin
          cmp_vld_d = 1'b0;
          done_d    = 1'b1;
          status_d  = StCovered;
          state_d   = SIdle;
        end else begin
          if (cmp_vld_q) begin
            if (hit_hi) begin
              have_hi_d = 1'b1;
              hi_idx_d  = cmp_idx_q;
              hi_high_d = rd_high_q;
            end
            if (hit_lo) begin
              have_lo_d = 1'b1;
              lo_idx_d  = cmp_idx_q;
            end
            if (hit_last) begin
              last_low_d  = rd_low_q;
              last_high_d = rd_high_q;
            end
          end
          if (!rd_en) begin
            state_d = SDecide;
          end
        end
      end

      SDecide: begin
        priority if (!have_lo_q && !have_hi_q) begin
          done_d  = 1'b1;
          state_d = SIdle;
          if (count_q == CntW'(MAX_INTERVALS)) begin
            status_d = StFull;
          end else begin
            // Append a single-point interval.
            low_we     = 1'b1;
            high_we    = 1'b1;
            low_waddr  = count_q[IdxW-1:0];
            high_waddr = count_q[IdxW-1:0];
            count_d    = count_q + CntW'(1);
            status_d   = StNew;
          end
        end else if (!have_lo_q) begin
          low_we   = 1'b1;
          done_d   = 1'b1;
          status_d = StGrewDown;
          state_d  = SIdle;
        end else if (!have_hi_q) begin
          high_we  = 1'b1;
          done_d   = 1'b1;
          status_d = StGrewUp;
          state_d  = SIdle;
        end else begin
          // Join: the lower interval takes the upper one's high end.
          high_we    = 1'b1;
          high_wdata = hi_high_q;
          count_d    = count_q - CntW'(1);
          if ((CntW'(hi_idx_q) + CntW'(1)) < count_q) begin
            state_d = SMove;
          end else begin
            // The absorbed interval was the last entry: drop it.
            done_d   = 1'b1;
            status_d = StJoined;
            state_d  = SIdle;
          end
        end
      end

      SMove: begin
        // Move the last entry into the freed slot. If the last entry is the
        // lower interval just widened, forward its new high end.
        low_we     = 1'b1;
        high_we    = 1'b1;
        low_waddr  = hi_idx_q;
        high_waddr = hi_idx_q;
        low_wdata  = last_low_q;
        if (CntW'(lo_idx_q) == count_q) begin
          high_wdata = hi_high_q;
        end else begin
          high_wdata = last_high_q;
        end
        done_d   = 1'b1;
        status_d = StJoined;
        state_d  = SIdle;
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

`default_nettype wire
